// ===== rtl/core/archive_record_chain_parser_defines.svh =====
// Assertion macros for the archive record chain parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef ARCHIVE_RECORD_CHAIN_PARSER_DEFINES_SVH
`define ARCHIVE_RECORD_CHAIN_PARSER_DEFINES_SVH

// Same-cycle implication, checks off while reset is high.
`define ARCP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checks off while reset is high.
`define ARCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/arcp_pkg.sv =====
// Shared types, constants and helpers for the archive record chain parser.
// No dependencies; imported by archive_record_chain_parser.
package arcp_pkg;

   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 208;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_ADDR_W  = 4;

   localparam int MAX_MEMBERS      = 65536;
   localparam int MAX_MEMBER_BYTES = 536870912;

   localparam logic [31:0] TAG_WORD = 32'h0031_4253;
   localparam int HDR_LEN  = 14;
   localparam int OVERHEAD = 18;

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // register index taken from paddr[3]
   localparam logic REG_BASE_OFFSET  = 1'b0;
   localparam logic REG_CHAIN_LENGTH = 1'b1;

   localparam logic [1:0] EV_ACCEPT   = 2'd0;
   localparam logic [1:0] EV_COMPLETE = 2'd1;
   localparam logic [1:0] EV_ERROR    = 2'd2;

   localparam logic [3:0] ERR_BAD_TAG     = 4'd0;
   localparam logic [3:0] ERR_EMPTY_NAME  = 4'd1;
   localparam logic [3:0] ERR_SHORT_REC   = 4'd2;
   localparam logic [3:0] ERR_HDR_BEYOND  = 4'd3;
   localparam logic [3:0] ERR_TAIL_BEYOND = 4'd4;
   localparam logic [3:0] ERR_SIZE_LIMIT  = 4'd5;
   localparam logic [3:0] ERR_DATA_BEYOND = 4'd6;
   localparam logic [3:0] ERR_DATA_MISS   = 4'd7;
   localparam logic [3:0] ERR_TOO_MANY    = 4'd8;

   typedef struct packed {
      logic [1:0]  event_res;
      logic [3:0]  error_code;
      logic [39:0] header_offset;
      logic [39:0] data_offset;
      logic [29:0] packed_size;
      logic [29:0] unpacked_size;
      logic [15:0] dos_date;
      logic [15:0] dos_time;
      logic [7:0]  attributes;
      logic [7:0]  name_length;
      logic [15:0] member_index;
      logic        last;
   } rsp_item_type;

   function automatic rsp_item_type make_error(input logic [3:0]  code,
                                               input logic [39:0] hdr_off,
                                               input logic [15:0] idx);
      rsp_item_type r;
      r = '0;
      r.event_res     = EV_ERROR;
      r.error_code    = code;
      r.header_offset = hdr_off;
      r.member_index  = idx;
      return r;
   endfunction

   function automatic rsp_item_type make_complete();
      rsp_item_type r;
      r = '0;
      r.event_res = EV_COMPLETE;
      return r;
   endfunction

endpackage

// ===== rtl/core/archive_record_chain_parser.sv =====
// Archive record chain parser: byte stream in, record/completion/error results out.
// Depends on arcp_pkg and archive_record_chain_parser_defines.svh.
// Takes one chain byte per transaction and sustains one byte per clock unless req_tready
// drops. A byte is registered, then parsed in the next cycle, and any results (at most
// two per byte: an accepted record and a chain completion) are written into an 8-entry
// result queue whose head drives rsp. req_tready drops only while more than four
// results wait in that queue. base_offset (0x0) and chain_length (0x8) are 40-bit
// registers on the csr port; write them while no results are pending. After an
// error or a completion further bytes are swallowed without results until reset.
`include "archive_record_chain_parser_defines.svh"

module archive_record_chain_parser (
   input  logic                               clock,
   input  logic                               reset,
   // csr
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [arcp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [arcp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [arcp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   // input bytes
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [arcp_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [7:0] data_byte
   // results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] error_code, [43:4] header_offset, [83:44] data_offset,
   // [113:84] packed_size, [143:114] unpacked_size, [159:144] dos_date,
   // [175:160] dos_time, [183:176] attributes, [191:184] name_length,
   // [207:192] member_index
   output logic [arcp_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic [arcp_pkg::RSP_TUSER_W-1:0]   rsp_tuser,  // [1:0] event_res
   output logic                               rsp_tlast
);
   import arcp_pkg::*;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_NAME   = 3'd1;
   localparam logic [2:0] PH_SIZE   = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;
   localparam logic [2:0] PH_HALT   = 3'd5;

   // configuration
   logic [39:0] base_offset_ff, chain_length_ff;
   logic        csr_write;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // parser state
   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  fp_ff, fp_in;
   logic [7:0]  hb_ff [HDR_LEN];
   logic        hb_we;
   logic [31:0] tail_ff, tail_in;
   logic [29:0] skip_ff, skip_in;
   logic [31:0] pk_ff, pk_in;
   logic [39:0] chain_pos_ff, chain_pos_in;
   logic [39:0] record_start_ff, record_start_in;
   logic [16:0] members_seen_ff, members_seen_in;

   // datapath
   logic signed [40:0] rem;
   logic signed [40:0] tail_need;
   logic signed [32:0] hdr_diff;
   logic [39:0]        pos_inc, start_abs, hdr_abs, data_abs;
   logic [31:0]        tail_new;
   logic [29:0]        skip_dec;
   logic               stopped, e4, e5, e6, e7;

   // results
   rsp_item_type        res0, res1, head;
   logic [1:0]          res_count;
   rsp_item_type        fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]    count_ff;
   logic                pop;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_offset_ff  <= '0;
         chain_length_ff <= '0;
      end else if (csr_write) begin
         case (csr_paddr[3])
            REG_BASE_OFFSET:  base_offset_ff  <= csr_pwdata[39:0];
            REG_CHAIN_LENGTH: chain_length_ff <= csr_pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3])
         REG_BASE_OFFSET:  csr_prdata = {24'd0, base_offset_ff};
         REG_CHAIN_LENGTH: csr_prdata = {24'd0, chain_length_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   // room for the byte in flight plus the one taken now, two results each
   assign req_tready = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 4));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // ---------------- parse ----------------
   assign rem       = {1'b0, chain_length_ff} - {1'b0, chain_pos_ff};
   assign tail_need = {33'd0, in_byte_ff} + 41'd5;
   assign hdr_diff  = {hb_ff[7][7], hb_ff[7], hb_ff[6], hb_ff[5], hb_ff[4]}
                      - {25'd0, in_byte_ff} - 33'(OVERHEAD);
   assign pos_inc   = chain_pos_ff + 40'd1;
   assign start_abs = base_offset_ff + chain_pos_ff;
   assign hdr_abs   = base_offset_ff + record_start_ff;
   assign data_abs  = base_offset_ff + chain_pos_ff + 40'd1;
   assign tail_new  = tail_ff | ({24'd0, in_byte_ff} << {fp_ff[1:0], 3'b000});
   assign skip_dec  = (skip_ff != '0) ? skip_ff - 30'd1 : '0;
   assign stopped   = (phase_ff == PH_DONE) || (phase_ff == PH_HALT);

   // name plus size word past the end; a position already beyond the end
   // leaves a negative signed remainder that fails rem > 0, so it never trips this
   assign e4 = (rem > 41'sd0) && (rem < tail_need);
   assign e5 = tail_new[31] || (tail_new > 32'(MAX_MEMBER_BYTES))
               || (pk_ff > 32'(MAX_MEMBER_BYTES));
   // packed data must fit in what is left after this byte
   assign e6 = (rem < 41'sd1) || ($signed({9'd0, pk_ff}) >= rem);
   assign e7 = (pk_ff == '0) && (tail_new != '0);

   always_comb begin
      phase_in        = phase_ff;
      fp_in           = fp_ff;
      tail_in         = tail_ff;
      skip_in         = skip_ff;
      pk_in           = pk_ff;
      chain_pos_in    = chain_pos_ff;
      record_start_in = record_start_ff;
      members_seen_in = members_seen_ff;
      hb_we           = 1'b0;
      res0            = '0;
      res1            = '0;
      res_count       = 2'd0;

      if (in_valid_ff && !stopped) begin
         if (phase_ff == PH_HEADER && fp_ff == '0
             && (members_seen_ff >= 17'(MAX_MEMBERS) || rem < 41'sd14)) begin
            // record start refused; the byte is not consumed
            record_start_in = chain_pos_ff;
            res0      = make_error((members_seen_ff >= 17'(MAX_MEMBERS)) ? ERR_TOO_MANY
                                   : ERR_HDR_BEYOND, start_abs, members_seen_ff[15:0]);
            res_count = 2'd1;
            phase_in  = PH_HALT;
         end else begin
            chain_pos_in = pos_inc;
            case (phase_ff)
               PH_HEADER: begin
                  if (fp_ff == '0) begin
                     record_start_in = chain_pos_ff;
                  end
                  hb_we = 1'b1;
                  fp_in = fp_ff + 4'd1;
                  if (fp_ff == 4'(HDR_LEN - 1)) begin
                     fp_in = '0;
                     pk_in = hdr_diff[31:0];
                     if ({hb_ff[3], hb_ff[2], hb_ff[1], hb_ff[0]} != TAG_WORD) begin
                        res0 = make_error(ERR_BAD_TAG, hdr_abs, members_seen_ff[15:0]);
                     end else if (in_byte_ff == '0) begin
                        res0 = make_error(ERR_EMPTY_NAME, hdr_abs, members_seen_ff[15:0]);
                     end else if (hdr_diff[32]) begin
                        res0 = make_error(ERR_SHORT_REC, hdr_abs, members_seen_ff[15:0]);
                     end else if (e4) begin
                        res0 = make_error(ERR_TAIL_BEYOND, hdr_abs, members_seen_ff[15:0]);
                     end
                     if ({hb_ff[3], hb_ff[2], hb_ff[1], hb_ff[0]} != TAG_WORD
                         || in_byte_ff == '0 || hdr_diff[32] || e4) begin
                        res_count = 2'd1;
                        phase_in  = PH_HALT;
                     end else begin
                        phase_in = PH_NAME;
                        skip_in  = {22'd0, in_byte_ff};
                     end
                  end
               end
               PH_NAME: begin
                  skip_in = skip_dec;
                  if (skip_dec == '0) begin
                     phase_in = PH_SIZE;
                     fp_in    = '0;
                     tail_in  = '0;
                  end
               end
               PH_SIZE: begin
                  tail_in = tail_new;
                  fp_in   = fp_ff + 4'd1;
                  if (fp_ff == 4'd3) begin
                     fp_in = '0;
                     if (e5 || e6 || e7) begin
                        res0 = make_error(e5 ? ERR_SIZE_LIMIT : e6 ? ERR_DATA_BEYOND
                                          : ERR_DATA_MISS, hdr_abs, members_seen_ff[15:0]);
                        res_count = 2'd1;
                        phase_in  = PH_HALT;
                     end else begin
                        res0.event_res     = EV_ACCEPT;
                        res0.error_code    = ERR_BAD_TAG;
                        res0.header_offset = hdr_abs;
                        res0.data_offset   = data_abs;
                        res0.packed_size   = pk_ff[29:0];
                        res0.unpacked_size = tail_new[29:0];
                        res0.dos_date      = {hb_ff[9], hb_ff[8]};
                        res0.dos_time      = {hb_ff[11], hb_ff[10]};
                        res0.attributes    = hb_ff[12];
                        res0.name_length   = hb_ff[13];
                        res0.member_index  = members_seen_ff[15:0];
                        res_count          = 2'd1;
                        members_seen_in    = members_seen_ff + 17'd1;
                        if (pk_ff == '0) begin
                           phase_in = PH_HEADER;
                           if (rem == 41'sd1) begin
                              res1      = make_complete();
                              res_count = 2'd2;
                              phase_in  = PH_DONE;
                           end
                        end else begin
                           phase_in = PH_DATA;
                           skip_in  = pk_ff[29:0];
                        end
                     end
                  end
               end
               PH_DATA: begin
                  skip_in = skip_dec;
                  if (skip_dec == '0) begin
                     phase_in = PH_HEADER;
                     fp_in    = '0;
                     if (rem == 41'sd1) begin
                        res0      = make_complete();
                        res_count = 2'd1;
                        phase_in  = PH_DONE;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (res_count == 2'd1) begin
            res0.last = 1'b1;
         end else if (res_count == 2'd2) begin
            res1.last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         fp_ff           <= '0;
         skip_ff         <= '0;
         chain_pos_ff    <= '0;
         record_start_ff <= '0;
         members_seen_ff <= '0;
      end else begin
         phase_ff        <= phase_in;
         fp_ff           <= fp_in;
         skip_ff         <= skip_in;
         chain_pos_ff    <= chain_pos_in;
         record_start_ff <= record_start_in;
         members_seen_ff <= members_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff <= tail_in;
      pk_ff   <= pk_in;
      if (hb_we) begin
         hb_ff[fp_ff] <= in_byte_ff;
      end
   end

   // ---------------- result queue ----------------
   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tuser  = head.event_res;
   assign rsp_tlast  = head.last;
   assign rsp_tdata  = {head.member_index, head.name_length, head.attributes,
                        head.dos_time, head.dos_date, head.unpacked_size,
                        head.packed_size, head.data_offset, head.header_offset,
                        head.error_code};

   always_ff @(posedge clock) begin
      if (res_count != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (res_count == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(res_count);
         rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(pop);
         count_ff  <= count_ff + (FIFO_AW+1)'(res_count) - (FIFO_AW+1)'(pop);
      end
   end

   // ---------------- checks ----------------
   `ARCP_ASSERT_SAME(a_queue_bound, clock, reset, 1'b1, count_ff <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
   `ARCP_ASSERT_NEXT(a_stop_holds, clock, reset, phase_ff == PH_DONE || phase_ff == PH_HALT, phase_ff == $past(phase_ff), "parser left a terminal phase")
   `ARCP_ASSERT_SAME(a_quiet_when_stopped, clock, reset, stopped, res_count == 2'd0, "result after error or completion")
   `ARCP_ASSERT_SAME(a_member_cap, clock, reset, 1'b1, members_seen_ff <= 17'(MAX_MEMBERS), "member count beyond cap")

endmodule

// ===== verif/archive_record_chain_parser_test.sv =====
// Self-checking testbench for archive_record_chain_parser: streams record chains into the
// byte port, predicts each result from its own parser model and compares fields.
// Depends on arcp_pkg and the parser RTL only.
module archive_record_chain_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import arcp_pkg::*;

   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BYTES   = 140;
   localparam int DRAIN_CYCLES  = 16;
   localparam int SEND_IDLE[4]  = '{0, 72, 0, 24};
   localparam int RECV_STALL[4] = '{0, 0, 72, 24};
   localparam logic [39:0] ALL_ONES40 = '1;

   localparam logic [2:0] ST_HEADER = 3'd0;
   localparam logic [2:0] ST_NAME   = 3'd1;
   localparam logic [2:0] ST_SIZE   = 3'd2;
   localparam logic [2:0] ST_DATA   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;
   localparam logic [2:0] ST_HALT   = 3'd5;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   archive_record_chain_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #2 clock = ~clock;

   // stimulus and scoreboard state
   logic [7:0]   pending_bytes[$];
   logic [7:0]   phase_bytes[$];
   rsp_item_type expected_results[$];
   rsp_item_type got_result;
   rsp_item_type want_result;
   logic [39:0]  stream_pos = '0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   bit           req_taken = 1'b0;
   int           mismatches = 0;
   int           bytes_taken = 0;
   int           results_checked = 0;
   int           records_accepted = 0;

   // parser model state
   logic [39:0]  cfg_base   = '0;
   logic [39:0]  cfg_length = '0;
   logic [2:0]   pstate     = ST_HEADER;
   int           fpos       = 0;
   logic [7:0]   header_buf[14] = '{default: 8'h00};
   logic [31:0]  size_word  = '0;
   logic [31:0]  skip_left  = '0;
   logic [39:0]  chain_pos  = '0;
   logic [39:0]  rec_start  = '0;
   int unsigned  members_done = 0;

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic rsp_item_type fault(input logic [3:0] code);
      rsp_item_type r;
      r = '0;
      r.event_res     = EV_ERROR;
      r.error_code    = code;
      r.header_offset = cfg_base + rec_start;
      r.member_index  = members_done[15:0];
      pstate = ST_HALT;
      return r;
   endfunction

   function automatic rsp_item_type completion();
      rsp_item_type r;
      r = '0;
      r.event_res = EV_COMPLETE;
      pstate = ST_DONE;
      return r;
   endfunction

   // Advance the parser model by one chain byte and queue the results it causes.
   task automatic parse_byte(input logic [7:0] b);
      rsp_item_type      found[2];
      int                n;
      logic [7:0]        nlen;
      logic signed [31:0] rsize;
      logic signed [31:0] usize;
      logic [63:0]       pk;
      n = 0;
      if (pstate == ST_DONE || pstate == ST_HALT)
         return;
      // record start: room for a header and the member limit are checked first
      if (pstate == ST_HEADER && fpos == 0) begin
         rec_start = chain_pos;
         if (members_done >= MAX_MEMBERS) begin
            found[n] = fault(ERR_TOO_MANY);
            n++;
         end else if (chain_pos >= cfg_length || cfg_length - chain_pos < HDR_LEN) begin
            found[n] = fault(ERR_HDR_BEYOND);
            n++;
         end
      end
      if (n == 0) begin
         chain_pos = chain_pos + 40'd1;
         nlen  = header_buf[13];
         rsize = {header_buf[7], header_buf[6], header_buf[5], header_buf[4]};
         case (pstate)
            ST_HEADER: begin
               header_buf[fpos] = b;
               fpos++;
               if (fpos == HDR_LEN) begin
                  fpos  = 0;
                  nlen  = header_buf[13];
                  rsize = {header_buf[7], header_buf[6], header_buf[5], header_buf[4]};
                  if ({header_buf[3], header_buf[2], header_buf[1], header_buf[0]} != TAG_WORD)
                  begin
                     found[n] = fault(ERR_BAD_TAG);
                     n++;
                  end else if (nlen == 0) begin
                     found[n] = fault(ERR_EMPTY_NAME);
                     n++;
                  end else if (longint'(rsize) < longint'(nlen) + OVERHEAD) begin
                     found[n] = fault(ERR_SHORT_REC);
                     n++;
                  end else if ({24'd0, cfg_length} - {24'd0, chain_pos} < 64'(nlen) + 64'd4)
                  begin
                     found[n] = fault(ERR_TAIL_BEYOND);
                     n++;
                  end else begin
                     pstate    = ST_NAME;
                     skip_left = 32'(nlen);
                  end
               end
            end
            ST_NAME: begin
               if (skip_left > 0)
                  skip_left--;
               if (skip_left == 0) begin
                  pstate    = ST_SIZE;
                  fpos      = 0;
                  size_word = '0;
               end
            end
            ST_SIZE: begin
               size_word = size_word | (32'(b) << (8 * fpos));
               fpos++;
               if (fpos == 4) begin
                  fpos  = 0;
                  usize = size_word;
                  pk    = 64'(longint'(rsize) - longint'(nlen) - OVERHEAD);
                  if (usize < 0 || usize > MAX_MEMBER_BYTES || pk > MAX_MEMBER_BYTES) begin
                     found[n] = fault(ERR_SIZE_LIMIT);
                     n++;
                  end else if (chain_pos > cfg_length || pk > 64'(cfg_length - chain_pos))
                  begin
                     found[n] = fault(ERR_DATA_BEYOND);
                     n++;
                  end else if (pk == 0 && usize != 0) begin
                     found[n] = fault(ERR_DATA_MISS);
                     n++;
                  end else begin
                     found[n] = '0;
                     found[n].event_res     = EV_ACCEPT;
                     found[n].header_offset = cfg_base + rec_start;
                     found[n].data_offset   = cfg_base + chain_pos;
                     found[n].packed_size   = pk[29:0];
                     found[n].unpacked_size = usize[29:0];
                     found[n].dos_date      = {header_buf[9], header_buf[8]};
                     found[n].dos_time      = {header_buf[11], header_buf[10]};
                     found[n].attributes    = header_buf[12];
                     found[n].name_length   = nlen;
                     found[n].member_index  = members_done[15:0];
                     n++;
                     members_done++;
                     if (pk == 0) begin
                        // empty data: the size word itself can close the chain
                        pstate = ST_HEADER;
                        if (chain_pos == cfg_length) begin
                           found[n] = completion();
                           n++;
                        end
                     end else begin
                        pstate    = ST_DATA;
                        skip_left = pk[31:0];
                     end
                  end
               end
            end
            ST_DATA: begin
               if (skip_left > 0)
                  skip_left--;
               if (skip_left == 0) begin
                  pstate = ST_HEADER;
                  fpos   = 0;
                  if (chain_pos == cfg_length) begin
                     found[n] = completion();
                     n++;
                  end
               end
            end
            default: ;
         endcase
      end
      if (n > 0) begin
         found[n-1].last = 1'b1;
         for (int i = 0; i < n; i++)
            expected_results.push_back(found[i]);
      end
   endtask

   // byte source and result sink, driven on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tdata  <= pending_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // transaction monitor: predict on accepted bytes, check accepted results
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         parse_byte(req_tdata);
         bytes_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result.event_res     = rsp_tuser[1:0];
         got_result.error_code    = rsp_tdata[3:0];
         got_result.header_offset = rsp_tdata[43:4];
         got_result.data_offset   = rsp_tdata[83:44];
         got_result.packed_size   = rsp_tdata[113:84];
         got_result.unpacked_size = rsp_tdata[143:114];
         got_result.dos_date      = rsp_tdata[159:144];
         got_result.dos_time      = rsp_tdata[175:160];
         got_result.attributes    = rsp_tdata[183:176];
         got_result.name_length   = rsp_tdata[191:184];
         got_result.member_index  = rsp_tdata[207:192];
         got_result.last          = rsp_tlast;
         if (expected_results.size() == 0) begin
            $error("result with no transaction pending: event_res 0x%0h, error_code 0x%0h",
                   got_result.event_res, got_result.error_code);
            mismatches++;
         end else begin
            want_result = expected_results.pop_front();
            results_checked++;
            if (want_result.event_res == EV_ACCEPT)
               records_accepted++;
            check_field("event_res", want_result.event_res, got_result.event_res);
            check_field("error_code", want_result.error_code, got_result.error_code);
            check_field("header_offset", want_result.header_offset, got_result.header_offset);
            check_field("data_offset", want_result.data_offset, got_result.data_offset);
            check_field("packed_size", want_result.packed_size, got_result.packed_size);
            check_field("unpacked_size", want_result.unpacked_size, got_result.unpacked_size);
            check_field("dos_date", want_result.dos_date, got_result.dos_date);
            check_field("dos_time", want_result.dos_time, got_result.dos_time);
            check_field("attributes", want_result.attributes, got_result.attributes);
            check_field("name_length", want_result.name_length, got_result.name_length);
            check_field("member_index", want_result.member_index, got_result.member_index);
            check_field("last", want_result.last, got_result.last);
         end
      end
   end

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [63:0] wdata, output logic [63:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register with junk above bit 39, then read it back
   task automatic set_register(input logic idx, input logic [39:0] value);
      logic [63:0] readback;
      csr_access(1'b1, {idx, 3'b000}, {24'($urandom()), value}, readback);
      if (idx == REG_BASE_OFFSET)
         cfg_base = value;
      else
         cfg_length = value;
      csr_access(1'b0, {idx, 3'b000}, '0, readback);
      check_field(idx == REG_BASE_OFFSET ? "base_offset readback" : "chain_length readback",
                  {24'd0, value}, readback);
   endtask

   task automatic wait_until_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_phase(input int mode);
      @(posedge clock);
      send_idle_pct  = SEND_IDLE[mode];
      recv_stall_pct = RECV_STALL[mode];
      foreach (phase_bytes[i])
         pending_bytes.push_back(phase_bytes[i]);
      stream_pos = stream_pos + 40'(phase_bytes.size());
      phase_bytes.delete();
   endtask

   function automatic void append_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         phase_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic void append_noise(input int count);
      repeat (count) phase_bytes.push_back(8'($urandom()));
   endfunction

   function automatic void append_header(input logic [31:0] tag, input logic [31:0] rsize,
                                         input logic [15:0] date, input logic [15:0] dtime,
                                         input logic [7:0] attr, input logic [7:0] nlen);
      append_word(tag);
      append_word(rsize);
      append_word({dtime, date});
      phase_bytes.push_back(attr);
      phase_bytes.push_back(nlen);
   endfunction

   function automatic void append_record(input int nlen, input int pk, input logic [31:0] up,
                                         input logic [15:0] date, input logic [15:0] dtime,
                                         input logic [7:0] attr);
      append_header(TAG_WORD, 32'(nlen + OVERHEAD + pk), date, dtime, attr, 8'(nlen));
      append_noise(nlen);
      append_word(up);
      append_noise(pk);
   endfunction

   initial begin : stimulus
      logic [63:0] readback;
      logic [39:0] phase_end;
      logic [39:0] base_val;
      logic [39:0] length_val;
      logic [31:0] up;
      logic [15:0] hdr_date;
      logic [15:0] hdr_time;
      logic [7:0]  hdr_attr;
      logic [3:0]  end_code;
      bit          end_complete;
      int          pick;
      int          nl;
      int          pk;
      string       end_note;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_access(1'b0, {REG_BASE_OFFSET, 3'b000}, '0, readback);
      check_field("base_offset after reset", '0, readback);
      csr_access(1'b0, {REG_CHAIN_LENGTH, 3'b000}, '0, readback);
      check_field("chain_length after reset", '0, readback);

      // Phase 0 is directed: smallest legal record, then one with date, time and attributes
      // at their top values and the largest unpacked size. The chain stays open between
      // phases; the registers are rewritten while the parser sits at a record boundary.
      for (int p = 0; p <= RANDOM_PHASES; p++) begin
         if (p == 0) begin
            append_record(1, 0, 32'd0, 16'h0000, 16'h0000, 8'h00);
            append_record(1, 1, MAX_MEMBER_BYTES, 16'hFFFF, 16'hFFFF, 8'hFF);
         end else begin
            while (phase_bytes.size() < PHASE_BYTES) begin
               pick = $urandom_range(0, 99);
               nl = (pick < 3) ? 255 : (pick < 15) ? $urandom_range(9, 64)
                                                   : $urandom_range(1, 8);
               pick = $urandom_range(0, 99);
               pk = (pick < 8) ? $urandom_range(20, 80) : (pick < 40) ? 0
                                                        : $urandom_range(1, 16);
               pick = $urandom_range(0, 99);
               if (pk == 0 || pick < 10)
                  up = 0;
               else if (pick < 20)
                  up = MAX_MEMBER_BYTES;
               else if (pick < 30)
                  up = 1;
               else
                  up = $urandom_range(0, MAX_MEMBER_BYTES);
               append_record(nl, pk, up, 16'($urandom()), 16'($urandom()), 8'($urandom()));
            end
         end
         phase_end = stream_pos + 40'(phase_bytes.size());
         case (p % 4)
            0: base_val = '0;
            1: base_val = ALL_ONES40;
            2: base_val = {8'($urandom()), 32'($urandom())};
            default: base_val = ALL_ONES40 - 40'($urandom_range(0, 50));
         endcase
         // a length one past the phase keeps the chain open at its tightest
         case (p % 3)
            0: length_val = ALL_ONES40;
            1: length_val = phase_end + 40'd1;
            default: length_val = phase_end + 40'd1 + 40'($urandom_range(0, 1000));
         endcase
         set_register(REG_BASE_OFFSET, base_val);
         set_register(REG_CHAIN_LENGTH, length_val);
         load_phase(p % 4);
         wait_until_drained();
      end

      // Final record ends the chain: a completion or one of the format errors.
      // The member-count limit would take 65536 records, far beyond this run.
      end_complete = ($urandom_range(0, 8) == 0);
      end_code = 4'($urandom_range(ERR_BAD_TAG, ERR_DATA_MISS));
      hdr_date = 16'($urandom());
      hdr_time = 16'($urandom());
      hdr_attr = 8'($urandom());
      nl = $urandom_range(1, 8);
      pk = $urandom_range(1, 16);
      length_val = ALL_ONES40;
      if (end_complete) begin
         end_note = "a completion";
         if ($urandom_range(0, 1))
            pk = 0;
         append_record(nl, pk, pk != 0 ? 32'($urandom_range(0, MAX_MEMBER_BYTES)) : 32'd0,
                       hdr_date, hdr_time, hdr_attr);
         length_val = stream_pos + 40'(phase_bytes.size());
      end else begin
         end_note = $sformatf("format error code %0d", end_code);
         case (end_code)
            ERR_BAD_TAG:
               append_header(TAG_WORD ^ (32'd1 << $urandom_range(0, 31)),
                             32'(nl + OVERHEAD + pk), hdr_date, hdr_time, hdr_attr, 8'(nl));
            ERR_EMPTY_NAME:
               append_header(TAG_WORD, $urandom(), hdr_date, hdr_time, hdr_attr, 8'd0);
            ERR_SHORT_REC: begin
               nl = $urandom_range(1, 255);
               up = $urandom_range(0, 1) ? 32'($urandom_range(0, nl + OVERHEAD - 1))
                                         : {1'b1, 31'($urandom())};
               append_header(TAG_WORD, up, hdr_date, hdr_time, hdr_attr, 8'(nl));
            end
            ERR_HDR_BEYOND:
               length_val = ($urandom_range(0, 3) == 0) ? 40'd0
                          : stream_pos + 40'($urandom_range(0, HDR_LEN - 1));
            ERR_TAIL_BEYOND: begin
               append_header(TAG_WORD, 32'(nl + OVERHEAD + pk), hdr_date, hdr_time, hdr_attr,
                             8'(nl));
               length_val = stream_pos + HDR_LEN + 40'($urandom_range(0, nl + 3));
            end
            ERR_SIZE_LIMIT: begin
               case ($urandom_range(0, 2))
                  0: up = {1'b1, 31'($urandom())};
                  1: up = $urandom_range(MAX_MEMBER_BYTES + 1, 32'h7FFF_FFFF);
                  default: begin
                     up = $urandom_range(0, MAX_MEMBER_BYTES);
                     pk = MAX_MEMBER_BYTES + 1 + $urandom_range(0, 1 << 24);
                  end
               endcase
               append_header(TAG_WORD, 32'(nl + OVERHEAD + pk), hdr_date, hdr_time, hdr_attr,
                             8'(nl));
               append_noise(nl);
               append_word(up);
            end
            ERR_DATA_BEYOND: begin
               append_header(TAG_WORD, 32'(nl + OVERHEAD + pk), hdr_date, hdr_time, hdr_attr,
                             8'(nl));
               append_noise(nl);
               append_word(32'($urandom_range(0, MAX_MEMBER_BYTES)));
               length_val = stream_pos + HDR_LEN + 40'(nl + 4 + pk - 1);
            end
            ERR_DATA_MISS: begin
               append_header(TAG_WORD, 32'(nl + OVERHEAD), hdr_date, hdr_time, hdr_attr,
                             8'(nl));
               append_noise(nl);
               append_word(32'($urandom_range(1, MAX_MEMBER_BYTES)));
            end
            default: ;
         endcase
      end
      // trailing bytes must be swallowed without results
      append_noise($urandom_range(4, 20));
      set_register(REG_BASE_OFFSET, {8'($urandom()), 32'($urandom())});
      set_register(REG_CHAIN_LENGTH, length_val);
      load_phase($urandom_range(0, 3));
      wait_until_drained();

      $display("Streamed %0d chain bytes over %0d register settings; %0d results checked, %0d of them accepted records.",
               bytes_taken, RANDOM_PHASES + 2, results_checked, records_accepted);
      $display("The chain was closed by %s, followed by ignored bytes.", end_note);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/arcp_pkg.sv
rtl/core/archive_record_chain_parser.sv
verif/archive_record_chain_parser_test.sv
